// File: rtl/dmx_pkg.sv
// Shared types, constants and helper functions of the channel downmix and remap core.
package dmx_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int MAX_CH      = 8;
  localparam int CH_IDX_W    = 3;
  localparam int CNT_W       = 4;
  localparam int CODE_W      = 5;
  localparam int MAP_W       = 40;
  localparam int SLOT_CNT    = 16;
  localparam int SLOT_IDX_W  = 4;
  localparam int WEIGHT_W    = 17;
  localparam int PROD_W      = SAMPLE_W + WEIGHT_W;
  localparam int ACC_W       = 48;
  localparam int FRAC_W      = 15;
  localparam int ROUND_HALF  = 1 << (FRAC_W - 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int ADDR_W      = 6;
  localparam int DATA_W      = 64;
  localparam int REG_IDX_W   = 3;

  // Register indexes, taken from paddr[5:3].
  localparam logic [REG_IDX_W-1:0] REG_CHANNELS_IN    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CHANNELS_OUT   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAP_IN         = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAP_OUT        = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MAP_IN_ENABLE  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MAP_OUT_ENABLE = 3'd5;

  // Speaker position codes.
  localparam logic [CODE_W-1:0] POS_FL  = 5'd0;
  localparam logic [CODE_W-1:0] POS_FR  = 5'd1;
  localparam logic [CODE_W-1:0] POS_FC  = 5'd2;
  localparam logic [CODE_W-1:0] POS_LFE = 5'd3;
  localparam logic [CODE_W-1:0] POS_RL  = 5'd4;
  localparam logic [CODE_W-1:0] POS_RR  = 5'd5;
  localparam logic [CODE_W-1:0] POS_FCL = 5'd6;
  localparam logic [CODE_W-1:0] POS_FCR = 5'd7;
  localparam logic [CODE_W-1:0] POS_RC  = 5'd8;
  localparam logic [CODE_W-1:0] POS_SL  = 5'd9;
  localparam logic [CODE_W-1:0] POS_SR  = 5'd10;

  // Mix weights in Q1.15.
  localparam logic signed [WEIGHT_W-1:0] W_ONE  = 17'sd32768;
  localparam logic signed [WEIGHT_W-1:0] W_0707 = 17'sd23167;
  localparam logic signed [WEIGHT_W-1:0] W_086  = 17'sd28180;
  localparam logic signed [WEIGHT_W-1:0] W_M05  = -17'sd16384;
  localparam logic signed [WEIGHT_W-1:0] W_M0707 = -17'sd23167;
  localparam logic signed [WEIGHT_W-1:0] W_ZERO = 17'sd0;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_MIX,
    MODE_REMAP
  } dmx_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_L,
    ST_MUL_R,
    ST_ACC_R,
    ST_EMIT
  } dmx_state_e;

  typedef struct packed {
    logic [CNT_W-1:0] channels_in;
    logic [CNT_W-1:0] channels_out;
    logic [MAP_W-1:0] map_in;
    logic [MAP_W-1:0] map_out;
    logic             map_in_en;
    logic             map_out_en;
  } dmx_cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [CODE_W-1:0]          code;
    logic                       frame_end;
    dmx_mode_e                  mode;
  } dmx_cmd_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QPTR_W:0]   count;
  } dmx_qstat_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] wl;
    logic signed [WEIGHT_W-1:0] wr;
  } dmx_weights_t;

  // A count of zero acts as one and counts above the channel limit are clamped.
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v);
    if (v == '0) begin
      return CNT_W'(1);
    end else if (v > CNT_W'(MAX_CH)) begin
      return CNT_W'(MAX_CH);
    end
    return v;
  endfunction

  function automatic dmx_weights_t weights_of(input logic [CODE_W-1:0] code);
    dmx_weights_t w;
    unique case (code)
      POS_FL, POS_FCL, POS_SL: begin w.wl = W_ONE;   w.wr = W_ZERO;  end
      POS_FR, POS_FCR, POS_SR: begin w.wl = W_ZERO;  w.wr = W_ONE;   end
      POS_FC, POS_LFE:         begin w.wl = W_0707;  w.wr = W_0707;  end
      POS_RL:                  begin w.wl = W_086;   w.wr = W_M05;   end
      POS_RR:                  begin w.wl = W_M05;   w.wr = W_086;   end
      POS_RC:                  begin w.wl = W_0707;  w.wr = W_M0707; end
      default:                 begin w.wl = W_ZERO;  w.wr = W_ZERO;  end
    endcase
    return w;
  endfunction

  // Round half up to a whole sample (floor of acc plus half a step), then saturate.
  function automatic logic signed [SAMPLE_W-1:0] round_sat(
    input logic signed [ACC_W-1:0] acc
  );
    logic [ACC_W-1:0]        t;
    logic [ACC_W-FRAC_W-1:0] q;
    logic                    in_range;
    t = acc + ACC_W'(ROUND_HALF);
    q = t[ACC_W-1:FRAC_W];
    in_range = (q[ACC_W-FRAC_W-1:SAMPLE_W-1] == '0) ||
               (q[ACC_W-FRAC_W-1:SAMPLE_W-1] == '1);
    if (in_range) begin
      return q[SAMPLE_W-1:0];
    end else if (q[ACC_W-FRAC_W-1]) begin
      return {1'b1, {(SAMPLE_W-1){1'b0}}};
    end
    return {1'b0, {(SAMPLE_W-1){1'b1}}};
  endfunction

endpackage

// File: rtl/dmx_front.sv
// Front end: accepts input beats, tracks the channel position and classifies each sample.
module dmx_front import dmx_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  input  logic                       buffer_last_i,
  input  dmx_cfg_t                   cfg_i,
  input  logic                       q_full_i,
  output logic                       push_o,
  output dmx_cmd_t                   cmd_o
);

  logic [CH_IDX_W-1:0] ch_q, ch_d;
  logic [CNT_W-1:0]    cin;
  logic [CNT_W-1:0]    cout;
  logic                frame_end;
  dmx_mode_e           mode;

  always_comb begin
    cin  = eff_count(cfg_i.channels_in);
    cout = eff_count(cfg_i.channels_out);
    frame_end = buffer_last_i || ((CNT_W'(ch_q) + CNT_W'(1)) >= cin);

    priority if (!cfg_i.map_in_en) begin
      mode = MODE_PASS;
    end else if (cout <= CNT_W'(2)) begin
      mode = MODE_MIX;
    end else begin
      mode = MODE_REMAP;
    end

    push_o = in_valid_i && !q_full_i;

    cmd_o.sample    = sample_in_i;
    cmd_o.code      = cfg_i.map_in[CODE_W*ch_q +: CODE_W];
    cmd_o.frame_end = frame_end;
    cmd_o.mode      = mode;

    ch_d = ch_q;
    if (push_o) begin
      ch_d = frame_end ? '0 : ch_q + CH_IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q <= '0;
    end else begin
      ch_q <= ch_d;
    end
  end

endmodule

// File: rtl/dmx_queue.sv
// Two-entry command queue between the front end and the back end.
module dmx_queue import dmx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  dmx_cmd_t   cmd_i,
  input  logic       pop_i,
  output dmx_cmd_t   head_o,
  output dmx_qstat_t stat_o
);

  dmx_cmd_t          entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q + (QPTR_W+1)'(push_i) - (QPTR_W+1)'(pop_i);

    head_o       = entry_q[rd_ptr_q];
    stat_o.full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
    stat_o.empty = (count_q == '0);
    stat_o.count = count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// File: rtl/dmx_back.sv
// Back end: passes, mixes or stores each sample and sends the frame results out through a register.
module dmx_back import dmx_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dmx_cfg_t                   cfg_i,
  input  dmx_cmd_t                   head_i,
  input  logic                       q_empty_i,
  output logic                       pop_o,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output logic signed [SAMPLE_W-1:0] sample_out_o,
  output logic                       frame_last_o
);

  dmx_state_e state_q, state_d;

  logic signed [SAMPLE_W-1:0] d_q;
  logic [CODE_W-1:0]          code_q;
  logic                       end_q;
  dmx_mode_e                  mode_q;
  logic signed [PROD_W-1:0]   prod_q, prod_d;
  logic signed [ACC_W-1:0]    mix_l_q, mix_r_q;
  logic [CH_IDX_W-1:0]        k_q;
  logic signed [SAMPLE_W-1:0] slot_q [SLOT_CNT];
  logic [SLOT_CNT-1:0]        slot_vld_q;

  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;
  logic                       out_last_q;

  logic                       mul_en, mul_right, acc_l, acc_r;
  logic                       emit, frame_clr, slot_wr, out_free;
  logic [CNT_W-1:0]           cout, n_total;
  logic                       emit_last;
  dmx_weights_t               w;
  logic signed [ACC_W-1:0]    acc_sel;
  logic [CODE_W-1:0]          slot_code;
  logic                       slot_hit;
  logic signed [SAMPLE_W-1:0] emit_val;

  // Datapath helpers for the multiply and the result selection.
  always_comb begin
    cout     = eff_count(cfg_i.channels_out);
    w        = weights_of(code_q);
    prod_d   = d_q * (mul_right ? w.wr : w.wl);
    out_free = !out_valid_q || !out_stall_i;

    unique case (mode_q)
      MODE_MIX:   n_total = (cout == CNT_W'(1)) ? CNT_W'(1) : CNT_W'(2);
      MODE_REMAP: n_total = cout;
      default:    n_total = CNT_W'(1);
    endcase
    emit_last = ((CNT_W'(k_q) + CNT_W'(1)) == n_total);

    if (cout == CNT_W'(1)) begin
      acc_sel = mix_l_q + mix_r_q;
    end else begin
      acc_sel = (k_q == '0) ? mix_l_q : mix_r_q;
    end

    slot_code = cfg_i.map_out_en ? cfg_i.map_out[CODE_W*k_q +: CODE_W] : CODE_W'(k_q);
    slot_hit  = (slot_code < CODE_W'(SLOT_CNT)) &&
                slot_vld_q[slot_code[SLOT_IDX_W-1:0]];

    unique case (mode_q)
      MODE_MIX:   emit_val = round_sat(acc_sel);
      MODE_REMAP: emit_val = slot_hit ? slot_q[slot_code[SLOT_IDX_W-1:0]] : '0;
      default:    emit_val = d_q;
    endcase
  end

  // Sequencer: next state and control.
  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    mul_en    = 1'b0;
    mul_right = 1'b0;
    acc_l     = 1'b0;
    acc_r     = 1'b0;
    emit      = 1'b0;
    frame_clr = 1'b0;
    slot_wr   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          unique case (head_i.mode)
            MODE_MIX: state_d = ST_MUL_L;
            MODE_REMAP: begin
              slot_wr = 1'b1;
              if (head_i.frame_end) begin
                state_d = ST_EMIT;
              end
            end
            default: state_d = ST_EMIT;
          endcase
        end
      end
      ST_MUL_L: begin
        mul_en  = 1'b1;
        state_d = ST_MUL_R;
      end
      ST_MUL_R: begin
        mul_en    = 1'b1;
        mul_right = 1'b1;
        acc_l     = 1'b1;
        state_d   = ST_ACC_R;
      end
      ST_ACC_R: begin
        acc_r   = 1'b1;
        state_d = end_q ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          if (emit_last) begin
            frame_clr = end_q;
            state_d   = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_PASS;
      end_q       <= 1'b0;
      k_q         <= '0;
      mix_l_q     <= '0;
      mix_r_q     <= '0;
      slot_vld_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        mode_q <= head_i.mode;
        end_q  <= head_i.frame_end;
      end
      if (emit) begin
        k_q <= emit_last ? '0 : k_q + CH_IDX_W'(1);
      end
      // Every frame end clears the mix and the slots, whatever mode the frame ended in.
      if (frame_clr) begin
        mix_l_q    <= '0;
        mix_r_q    <= '0;
        slot_vld_q <= '0;
      end else begin
        if (acc_l) begin
          mix_l_q <= mix_l_q + ACC_W'(prod_q);
        end
        if (acc_r) begin
          mix_r_q <= mix_r_q + ACC_W'(prod_q);
        end
        if (slot_wr && (head_i.code < CODE_W'(SLOT_CNT))) begin
          slot_vld_q[head_i.code[SLOT_IDX_W-1:0]] <= 1'b1;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      d_q    <= head_i.sample;
      code_q <= head_i.code;
    end
    if (mul_en) begin
      prod_q <= prod_d;
    end
    if (slot_wr && (head_i.code < CODE_W'(SLOT_CNT))) begin
      slot_q[head_i.code[SLOT_IDX_W-1:0]] <= head_i.sample;
    end
    if (emit) begin
      out_sample_q <= emit_val;
      out_last_q   <= emit_last && end_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_sample_q;
  assign frame_last_o = out_last_q;

endmodule

// File: rtl/multichannel_downmix_remap_core.sv
// Top level of the channel downmix and remap core: register port, front end, queue, back end.
// The back end takes a downmix sample through idle, multiply left, multiply right and accumulate
// right (one shared 24x17 multiplier, left then right), a remap sample through idle alone and a
// pass-through sample through idle then emit, with an emit step per result at the end of a frame
// that an output stall can hold. A two-entry queue lets the input keep taking beats meanwhile.
// Reset: registers return to their defaults and the mix, slots and channel position clear.
module multichannel_downmix_remap_core import dmx_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  input  logic                       buffer_last_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] sample_out_o,
  output logic                       frame_last_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready
);

  logic [CNT_W-1:0]     channels_in_q, channels_out_q;
  logic [MAP_W-1:0]     map_in_q, map_out_q;
  logic                 map_in_en_q, map_out_en_q;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;
  dmx_cfg_t             cfg;

  logic       push, pop;
  dmx_cmd_t   cmd, head;
  dmx_qstat_t qstat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channels_in_q  <= CNT_W'(2);
      channels_out_q <= CNT_W'(2);
      map_in_q       <= '0;
      map_out_q      <= '0;
      map_in_en_q    <= 1'b0;
      map_out_en_q   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_CHANNELS_IN:    channels_in_q  <= pwdata[CNT_W-1:0];
        REG_CHANNELS_OUT:   channels_out_q <= pwdata[CNT_W-1:0];
        REG_MAP_IN:         map_in_q       <= pwdata[MAP_W-1:0];
        REG_MAP_OUT:        map_out_q      <= pwdata[MAP_W-1:0];
        REG_MAP_IN_ENABLE:  map_in_en_q    <= pwdata[0];
        REG_MAP_OUT_ENABLE: map_out_en_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CHANNELS_IN:    prdata = DATA_W'(channels_in_q);
      REG_CHANNELS_OUT:   prdata = DATA_W'(channels_out_q);
      REG_MAP_IN:         prdata = DATA_W'(map_in_q);
      REG_MAP_OUT:        prdata = DATA_W'(map_out_q);
      REG_MAP_IN_ENABLE:  prdata = DATA_W'(map_in_en_q);
      REG_MAP_OUT_ENABLE: prdata = DATA_W'(map_out_en_q);
      default:            prdata = '0;
    endcase
  end

  always_comb begin
    cfg.channels_in  = channels_in_q;
    cfg.channels_out = channels_out_q;
    cfg.map_in       = map_in_q;
    cfg.map_out      = map_out_q;
    cfg.map_in_en    = map_in_en_q;
    cfg.map_out_en   = map_out_en_q;
  end

  assign in_stall_o = qstat.full;

  dmx_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .sample_in_i   (sample_in_i),
    .buffer_last_i (buffer_last_i),
    .cfg_i         (cfg),
    .q_full_i      (qstat.full),
    .push_o        (push),
    .cmd_o         (cmd)
  );

  dmx_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (qstat)
  );

  dmx_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_i       (head),
    .q_empty_i    (qstat.empty),
    .pop_o        (pop),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .sample_out_o (sample_out_o),
    .frame_last_o (frame_last_o)
  );

  // The back end only takes a command that is really queued.
  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty)
    else $error("queue popped while empty");

  // The front end never writes into a full queue.
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !qstat.full)
    else $error("queue pushed while full");

  // Draining the last queued command leaves the queue empty.
  a_drain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push && (qstat.count == (QPTR_W+1)'(1))) |=> qstat.empty)
    else $error("queue not empty after its last command was taken");

endmodule

// File: tb/tb_multichannel_downmix_remap_core.sv
// Testbench for the channel downmix and remap core: predicts every output beat and checks it.
module tb_multichannel_downmix_remap_core;
  import dmx_pkg::*;

  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_TARGET = 230;

  // Q1.15 mix weights.
  localparam longint Q_UNITY = 32768;
  localparam longint Q_CENTER = 23167;
  localparam longint Q_REAR_NEAR = 28180;
  localparam longint Q_REAR_FAR = -16384;

  // Codes outside the speaker set.
  localparam logic [CODE_W-1:0] CODE_UNKNOWN = 5'd11;
  localparam logic [CODE_W-1:0] CODE_TOP_SLOT = 5'd15;
  localparam logic [CODE_W-1:0] CODE_UNUSED = 5'd16;
  localparam logic [CODE_W-1:0] CODE_UNUSED_MAX = 5'd31;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } audio_beat_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_in_i = '0;
  logic                       buffer_last_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out_o;
  logic                       frame_last_o;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [ADDR_W-1:0]          paddr = '0;
  logic [DATA_W-1:0]          pwdata = '0;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;

  multichannel_downmix_remap_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_in_i  (sample_in_i),
    .buffer_last_i(buffer_last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o),
    .frame_last_o (frame_last_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Shadow copy of the registers, starting from their reset values.
  logic [CNT_W-1:0] shadow_ch_in = CNT_W'(2);
  logic [CNT_W-1:0] shadow_ch_out = CNT_W'(2);
  logic [MAP_W-1:0] shadow_map_in = '0;
  logic [MAP_W-1:0] shadow_map_out = '0;
  logic             shadow_map_in_en = 1'b0;
  logic             shadow_map_out_en = 1'b0;

  // Frame state of the mixer.
  longint slot_values [SLOT_CNT];
  longint left_acc = 0;
  longint right_acc = 0;
  int     chan_pos = 0;

  audio_beat_t send_queue[$];
  audio_beat_t due_samples[$];
  audio_beat_t next_beat;

  int beats_queued = 0;
  int beats_taken = 0;
  int results_seen = 0;
  int mismatches = 0;
  int pass_phases = 0;
  int mix_phases = 0;
  int remap_phases = 0;

  int burst_left = 1;
  int gap_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int stall_run = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("Timed out with %0d results still due.", due_samples.size());
    $display("FAILURE");
    $finish;
  end

  function automatic int clamp_count(input logic [CNT_W-1:0] v);
    if (v == '0) return 1;
    if (v > CNT_W'(MAX_CH)) return MAX_CH;
    return int'(v);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] clip_sample(input longint v);
    if (v > longint'(S_MAX)) return S_MAX;
    if (v < longint'(S_MIN)) return S_MIN;
    return v[SAMPLE_W-1:0];
  endfunction

  // Half a step is added, then the arithmetic shift floors.
  function automatic logic signed [SAMPLE_W-1:0] round_to_sample(input longint acc);
    longint t;
    t = acc + 16384;
    return clip_sample(t >>> 15);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 11))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      3: return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [MAP_W-1:0] rand_map(input int top_code);
    logic [MAP_W-1:0] m;
    for (int n = 0; n < MAX_CH; n++) begin
      if ($urandom_range(0, 9) < 7) begin
        m[CODE_W*n +: CODE_W] = CODE_W'($urandom_range(0, top_code));
      end else begin
        m[CODE_W*n +: CODE_W] = CODE_W'($urandom_range(0, 31));
      end
    end
    return m;
  endfunction

  task automatic log_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic push_result(input longint v, input logic last);
    audio_beat_t r;
    r.sample = clip_sample(v);
    r.last = last;
    due_samples.push_back(r);
  endtask

  task automatic close_frame();
    foreach (slot_values[i]) slot_values[i] = 0;
    left_acc = 0;
    right_acc = 0;
    chan_pos = 0;
  endtask

  // Works out the output beats that one accepted input beat causes.
  task automatic mix_and_route(input logic signed [SAMPLE_W-1:0] s, input logic last);
    int               n_in;
    int               n_out;
    int               slot;
    logic             frame_end;
    logic [CODE_W-1:0] code;
    longint           d;
    n_in = clamp_count(shadow_ch_in);
    n_out = clamp_count(shadow_ch_out);
    d = longint'(s);
    frame_end = last || (chan_pos + 1 >= n_in);
    code = shadow_map_in[CODE_W*chan_pos +: CODE_W];
    beats_taken++;
    if (!shadow_map_in_en) begin
      push_result(d, frame_end);
    end else if (n_out <= 2) begin
      case (code)
        POS_FL, POS_FCL, POS_SL: left_acc += d * Q_UNITY;
        POS_FR, POS_FCR, POS_SR: right_acc += d * Q_UNITY;
        POS_FC, POS_LFE: begin
          left_acc += d * Q_CENTER;
          right_acc += d * Q_CENTER;
        end
        POS_RL: begin
          left_acc += d * Q_REAR_NEAR;
          right_acc += d * Q_REAR_FAR;
        end
        POS_RR: begin
          left_acc += d * Q_REAR_FAR;
          right_acc += d * Q_REAR_NEAR;
        end
        POS_RC: begin
          left_acc += d * Q_CENTER;
          right_acc -= d * Q_CENTER;
        end
        default: ;
      endcase
      if (frame_end) begin
        if (n_out == 1) begin
          push_result(round_to_sample(left_acc + right_acc), 1'b1);
        end else begin
          push_result(round_to_sample(left_acc), 1'b0);
          push_result(round_to_sample(right_acc), 1'b1);
        end
      end
    end else begin
      if (code < SLOT_CNT) slot_values[code] = d;
      if (frame_end) begin
        for (int k = 0; k < n_out; k++) begin
          slot = shadow_map_out_en ? int'(shadow_map_out[CODE_W*k +: CODE_W]) : k;
          push_result((slot < SLOT_CNT) ? slot_values[slot] : 0, k + 1 == n_out);
        end
      end
    end
    if (frame_end) close_frame();
    else chan_pos = chan_pos + 1;
  endtask

  task automatic next_result_check(input audio_beat_t want);
    if (sample_out_o !== want.sample) begin
      log_mismatch($sformatf("sample_out %0d, expected %0d", sample_out_o, want.sample));
    end
    if (frame_last_o !== want.last) begin
      log_mismatch($sformatf("frame_last %0b, expected %0b", frame_last_o, want.last));
    end
  endtask

  // Sender: bursts of beats with gaps between them; a stalled beat is held.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left <= 1;
      gap_left <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) mix_and_route(sample_in_i, buffer_last_i);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (send_queue.size() != 0) begin
          next_beat = send_queue.pop_front();
          in_valid_i <= 1'b1;
          sample_in_i <= next_beat.sample;
          buffer_last_i <= next_beat.last;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: free-running, coin-flip, or long runs, switched at random.
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left <= $urandom_range(20, 100);
      out_stall_i <= 1'b0;
    end else begin
      mode_left <= mode_left - 1;
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= 1'($urandom_range(0, 1));
        default: begin
          if (stall_run != 0) begin
            stall_run <= stall_run - 1;
            out_stall_i <= 1'b1;
          end else begin
            stall_run <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
            out_stall_i <= 1'b0;
          end
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (due_samples.size() == 0) begin
        log_mismatch($sformatf("unexpected beat sample=%0d last=%0b",
                               sample_out_o, frame_last_o));
      end else begin
        next_result_check(due_samples.pop_front());
      end
    end
  end

  // One write: setup, access, then idle before the next transfer.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CHANNELS_IN: shadow_ch_in = value[CNT_W-1:0];
      REG_CHANNELS_OUT: shadow_ch_out = value[CNT_W-1:0];
      REG_MAP_IN: shadow_map_in = value[MAP_W-1:0];
      REG_MAP_OUT: shadow_map_out = value[MAP_W-1:0];
      REG_MAP_IN_ENABLE: shadow_map_in_en = value[0];
      REG_MAP_OUT_ENABLE: shadow_map_out_en = value[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [CNT_W-1:0] n_in, input logic [CNT_W-1:0] n_out,
                           input logic [MAP_W-1:0] m_in, input logic [MAP_W-1:0] m_out,
                           input logic m_in_en, input logic m_out_en);
    write_reg(REG_CHANNELS_IN, DATA_W'(n_in));
    write_reg(REG_CHANNELS_OUT, DATA_W'(n_out));
    write_reg(REG_MAP_IN, DATA_W'(m_in));
    write_reg(REG_MAP_OUT, DATA_W'(m_out));
    write_reg(REG_MAP_IN_ENABLE, DATA_W'(m_in_en));
    write_reg(REG_MAP_OUT_ENABLE, DATA_W'(m_out_en));
    if (!m_in_en) pass_phases++;
    else if (clamp_count(n_out) <= 2) mix_phases++;
    else remap_phases++;
  endtask

  task automatic send(input logic signed [SAMPLE_W-1:0] s, input logic last);
    audio_beat_t b;
    b.sample = s;
    b.last = last;
    send_queue.push_back(b);
    beats_queued++;
  endtask

  // Waits until every queued beat is taken and every result is in.
  task automatic drain();
    while (beats_taken != beats_queued) @(posedge clk_i);
    while (due_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int               n_frames;
    int               frame_len;
    int               cut;
    logic [CNT_W-1:0] n_in;
    logic [CNT_W-1:0] n_out;
    logic             m_in_en;
    close_frame();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: pass-through of two-channel frames, with a flushed partial frame.
    send(S_MAX, 1'b0);
    send(S_MIN, 1'b1);
    send('0, 1'b1);
    send('1, 1'b0);
    send(SAMPLE_W'(1), 1'b0);
    drain();

    // Stereo downmix of a full 8-channel frame at full scale, which saturates.
    configure(CNT_W'(8), CNT_W'(2),
              {POS_FCR, POS_FCL, POS_RR, POS_RL, POS_LFE, POS_FC, POS_FR, POS_FL},
              '0, 1'b1, 1'b0);
    for (int i = 0; i < 8; i++) send(S_MAX, 1'b0);
    drain();

    // Mono with a clamped input count, rear center, sides and an unknown code.
    configure(CNT_W'(15), CNT_W'(1),
              {POS_RL, POS_FC, CODE_UNUSED_MAX, CODE_UNUSED, CODE_UNKNOWN, POS_SR, POS_SL,
               POS_RC},
              '0, 1'b1, 1'b0);
    send(S_MIN, 1'b0);
    send(S_MIN, 1'b0);
    send(S_MAX, 1'b0);
    send(S_MIN, 1'b1);
    drain();

    // Remap with a repeated input slot, a dropped sample and unused output slots.
    configure(CNT_W'(4), CNT_W'(15),
              {20'd0, CODE_UNUSED, CODE_TOP_SLOT, POS_RR, POS_RR},
              {POS_RL, POS_FC, POS_FR, POS_FL, CODE_UNUSED_MAX, CODE_UNUSED, CODE_TOP_SLOT,
               POS_RR},
              1'b1, 1'b1);
    send(S_MAX, 1'b0);
    send(S_MIN, 1'b0);
    send('1, 1'b0);
    send(SAMPLE_W'(12345), 1'b0);
    drain();

    // A zero input count acts as one, so every beat is a frame of its own.
    configure('0, CNT_W'(3), {8{POS_FL}}, '0, 1'b1, 1'b0);
    send(S_MIN, 1'b0);
    send(S_MAX, 1'b1);
    drain();

    while (beats_queued < RANDOM_TARGET) begin
      n_in = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 15)) :
                                           CNT_W'($urandom_range(1, 8));
      m_in_en = ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 2))
        0: n_out = CNT_W'(2);
        1: n_out = CNT_W'($urandom_range(0, 1));
        default: n_out = CNT_W'($urandom_range(3, 15));
      endcase
      configure(n_in, n_out, rand_map((n_out > 2) ? 15 : 10), rand_map(15), m_in_en,
                1'($urandom_range(0, 1)));
      frame_len = clamp_count(n_in);
      n_frames = $urandom_range(2, 6);
      for (int f = 0; f < n_frames; f++) begin
        cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, frame_len) : frame_len;
        for (int i = 0; i < cut; i++) begin
          if (i + 1 < cut) send(rand_sample(), 1'b0);
          else if (cut < frame_len) send(rand_sample(), 1'b1);
          else send(rand_sample(), $urandom_range(0, 3) == 0);
        end
      end
      drain();
    end

    if (due_samples.size() != 0) log_mismatch("results still due at the end");
    $display("Sent %0d beats and checked %0d results.", beats_taken, results_seen);
    $display("Settings run: %0d pass-through, %0d downmix, %0d remap.",
             pass_phases, mix_phases, remap_phases);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
